// ----- hdl/positional_list_engine_top_defines.svh -----
// ----------------------------------------------------------------------------
// positional list engine assertion macros
// shared property forms, sampled on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PLE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// shared codes, types and constants of the positional list engine
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 7;
	localparam int COUNT_W      = 7;
	// cells or'ed together in one read group
	localparam int RD_GROUP     = 32;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle operation broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic              rd;
		logic [DATA_W-1:0] new_value;
	} ple_op_t;

endpackage

`default_nettype wire

// ----- hdl/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds an entry, shifts from a neighbor on insert or remove
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
	parameter int CMP_W = 7,
	parameter int IDX   = 0
) (
	input  wire logic                      clk,
	input  wire logic [CMP_W-1:0]          pos,
	input  wire ple_pkg::ple_op_t          op,
	input  wire logic [ple_pkg::DATA_W-1:0] left,
	input  wire logic [ple_pkg::DATA_W-1:0] right,
	output logic      [ple_pkg::DATA_W-1:0] value,
	output logic      [ple_pkg::DATA_W-1:0] rd
);
	import ple_pkg::*;

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

	logic              hit;
	logic              above;
	logic [DATA_W-1:0] value_q;

	assign hit   = (pos == MY_IDX);
	assign above = (MY_IDX > pos);

	// entries carry no reset, slots at or above count are never read
	always_ff @(posedge clk) begin
		if (op.ins && above) begin
			value_q <= left;
		end else if (op.ins && hit) begin
			value_q <= op.new_value;
		end else if (op.rem && (above || hit)) begin
			value_q <= right;
		end
	end

	assign value = value_q;
	assign rd    = (op.rd && hit) ? value_q : '0;

endmodule

`default_nettype wire

// ----- hdl/ple_rd_tree.sv -----
// ----------------------------------------------------------------------------
// ple_rd_tree
// two-stage registered or tree over the masked read outputs of all cells
// ----------------------------------------------------------------------------
`default_nettype none

module ple_rd_tree #(
	parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
	input  wire logic                       clk,
	input  wire logic [ple_pkg::DATA_W-1:0] rd [CAPACITY],
	output logic      [ple_pkg::DATA_W-1:0] read_value
);
	import ple_pkg::*;

	localparam int NGRP = (CAPACITY + RD_GROUP - 1) / RD_GROUP;

	logic [DATA_W-1:0] grp_s1 [NGRP];
	logic [DATA_W-1:0] total;
	logic [DATA_W-1:0] read_s2;

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		logic [DATA_W-1:0] grp_or;

		always_comb begin
			grp_or = '0;
			for (int k = 0; k < RD_GROUP; k++) begin
				if (g * RD_GROUP + k < CAPACITY) begin
					grp_or = grp_or | rd[g * RD_GROUP + k];
				end
			end
		end

		always_ff @(posedge clk) begin
			grp_s1[g] <= grp_or;
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) begin
			total = total | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		read_s2 <= total;
	end

	assign read_value = read_s2;

endmodule

`default_nettype wire

// ----- hdl/positional_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_top
// ordered list of signed 32-bit entries with insert, remove and read by position
// ----------------------------------------------------------------------------
// A request beat is taken on every clock edge with start high; busy stays low,
// so one request per cycle is sustained. Each request gives exactly one result,
// shown on status, read_value and entry_count for the single cycle that done is
// high, once the request has passed the valid_s1 and done_q registers. The
// receiver cannot hold results off: they must be captured in that cycle. Insert
// and remove shift the row of cells in the request cycle itself; the read path
// is a two-stage registered or tree over the cells. No clearing pass is needed
// after reset.
`default_nettype none

`include "positional_list_engine_top_defines.svh"

module positional_list_engine_top #(
	parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  cmd,
	input  wire logic [ple_pkg::POS_W-1:0]   position,
	input  wire logic [ple_pkg::DATA_W-1:0]  new_value,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [ple_pkg::DATA_W-1:0]       read_value,
	output logic [ple_pkg::COUNT_W-1:0]      entry_count
);
	import ple_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic                acc;
	logic [CMP_W-1:0]    pos_ext;
	logic [CMP_W-1:0]    cnt_ext;
	logic                full;
	status_t             status_nxt;
	ple_op_t             op;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;

	logic                valid_s1;
	status_t             status_s1;
	logic [COUNT_W-1:0]  count_s1;
	logic                done_q;
	status_t             status_q;
	logic [COUNT_W-1:0]  entry_count_q;

	logic [DATA_W-1:0]   cell_value [CAPACITY];
	logic [DATA_W-1:0]   cell_rd    [CAPACITY];

	assign busy    = 1'b0;
	assign acc     = start && !busy;
	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);
	assign full    = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		status_nxt    = ST_RANGE;
		op.ins        = 1'b0;
		op.rem        = 1'b0;
		op.rd         = 1'b0;
		op.new_value  = new_value;
		count_nxt     = count_q;
		case (cmd)
			CMD_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_nxt = ST_RANGE;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					status_nxt = ST_DONE;
					op.ins     = acc;
					count_nxt  = count_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (pos_ext < cnt_ext) begin
					status_nxt = ST_DONE;
					op.rem     = acc;
					count_nxt  = count_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (pos_ext < cnt_ext) begin
					status_nxt = ST_DONE;
					op.rd      = acc;
				end
			end
			default: begin
				status_nxt = ST_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_nxt;
			end
			valid_s1 <= acc;
			done_q   <= valid_s1;
		end
	end

	// result fields travel beside the read tree stages
	always_ff @(posedge clk) begin
		status_s1     <= status_nxt;
		count_s1      <= COUNT_W'(count_nxt);
		status_q      <= status_s1;
		entry_count_q <= count_s1;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = new_value;
		end else begin : g_mid_l
			assign left = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right = cell_value[i];
		end else begin : g_mid_r
			assign right = cell_value[i+1];
		end

		ple_cell #(
			.CMP_W (CMP_W),
			.IDX   (i)
		) u_cell (
			.clk   (clk),
			.pos   (pos_ext),
			.op    (op),
			.left  (left),
			.right (right),
			.value (cell_value[i]),
			.rd    (cell_rd[i])
		);
	end

	ple_rd_tree #(
		.CAPACITY (CAPACITY)
	) u_rd_tree (
		.clk        (clk),
		.rd         (cell_rd),
		.read_value (read_value)
	);

	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	`PLE_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`PLE_ASSERT_NEXT(a_insert_grows, acc && op.ins, count_q == CNT_W'($past(count_q) + 1'b1), "insert did not grow count")
	`PLE_ASSERT_NEXT(a_full_holds, acc && (status_nxt == ST_FULL), $stable(count_q), "full insert changed count")
	`PLE_ASSERT_SAME(a_done_latency, done, $past(acc, 2), "result beat without a request")
	`PLE_ASSERT_SAME(a_read_zero, done && (read_value != '0), status == ST_DONE, "read value on failed request")

endmodule

`default_nettype wire
